// ===== rtl/tvst_pkg.sv =====
package tvst_pkg;

    typedef enum logic [1:0] {
        PH_TAG    = 2'd0,
        PH_NUM    = 2'd1,
        PH_CNTTAG = 2'd2,
        PH_PAY    = 2'd3
    } t_phase;

    typedef enum logic [2:0] {
        P_INT    = 3'd0,
        P_REAL   = 3'd1,
        P_SLEN   = 3'd2,
        P_COUNT  = 3'd3,
        P_FLEN   = 3'd4,
        P_SBYTES = 3'd5,
        P_FBYTES = 3'd6
    } t_purpose;

    // tag types (low 3 bits of a tag byte)
    localparam logic [2:0] TY_NIL   = 3'd0;
    localparam logic [2:0] TY_BOOL  = 3'd1;
    localparam logic [2:0] TY_NUM   = 3'd2;
    localparam logic [2:0] TY_SSTR  = 3'd4;
    localparam logic [2:0] TY_LSTR  = 3'd5;
    localparam logic [2:0] TY_TABLE = 3'd6;
    localparam logic [2:0] TY_FUNC  = 3'd7;

    // cookies (high 5 bits of a tag byte)
    localparam logic [4:0] CK_ZERO  = 5'd0;
    localparam logic [4:0] CK_BYTE  = 5'd1;
    localparam logic [4:0] CK_WORD  = 5'd2;
    localparam logic [4:0] CK_DWORD = 5'd4;
    localparam logic [4:0] CK_QWORD = 5'd6;
    localparam logic [4:0] CK_REAL  = 5'd8;
    localparam logic [4:0] CK_EXT   = 5'd31;

    // token kinds
    localparam logic [3:0] K_NIL       = 4'd0;
    localparam logic [3:0] K_BOOL      = 4'd1;
    localparam logic [3:0] K_INT       = 4'd2;
    localparam logic [3:0] K_REAL      = 4'd3;
    localparam logic [3:0] K_STR_HEAD  = 4'd4;
    localparam logic [3:0] K_STR_BYTE  = 4'd5;
    localparam logic [3:0] K_TAB_HEAD  = 4'd6;
    localparam logic [3:0] K_FUNC_HEAD = 4'd7;
    localparam logic [3:0] K_FUNC_BYTE = 4'd8;
    localparam logic [3:0] K_ERROR     = 4'd9;

    // error codes
    localparam logic [2:0] E_BAD_TYPE   = 3'd0;
    localparam logic [2:0] E_BAD_NUMCK  = 3'd1;
    localparam logic [2:0] E_BAD_LENCK  = 3'd2;
    localparam logic [2:0] E_BAD_CNTTAG = 3'd3;
    localparam logic [2:0] E_TRUNC      = 3'd4;
    localparam logic [2:0] E_NONE       = 3'd0;

endpackage

// ===== rtl/tvst_intf.sv =====
interface tvst_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       stream_end;

    modport source (output valid, output data_byte, output stream_end, input ready);
    modport sink   (input valid, input data_byte, input stream_end, output ready);
endinterface

interface tvst_out_if;
    logic        valid;
    logic        ready;
    logic [3:0]  token_kind;
    logic [63:0] token_value;
    logic [2:0]  error_code;

    modport source (output valid, output token_kind, output token_value, output error_code,
                    input ready);
    modport sink   (input valid, input token_kind, input token_value, input error_code,
                    output ready);
endinterface

// ===== rtl/tagged_value_stream_tokenizer.sv =====
// Channel   Dir  Payload                                    Handshake
// i_in      in   data_byte[7:0], stream_end                 valid/ready
// o_out     out  token_kind[3:0], token_value[63:0],        valid/ready
//                error_code[2:0]
//
// One byte per cycle unless the output stalls. The parse state and the token
// register load on the edge that takes a byte; its token is valid the next cycle.
// Input ready is high whenever the token register is empty or being drained,
// so a stalled output holds at most one token and back-pressures the input.
// Synchronous active-low reset returns the parser to tag phase, clears the
// sticky error and empties the token register.
module tagged_value_stream_tokenizer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    tvst_in_if.sink     i_in,
    tvst_out_if.source  o_out
);
    import tvst_pkg::*;

    t_phase      r_phase, n_phase;
    t_purpose    r_purpose, n_purpose;
    logic [31:0] r_rem, n_rem;
    logic [63:0] r_acc, n_acc;
    logic [3:0]  r_width, n_width;
    logic        r_err, n_err;

    logic        r_out_valid;
    logic [3:0]  r_kind;
    logic [63:0] r_value;
    logic [2:0]  r_code;

    logic        tk_have;
    logic [3:0]  tk_kind;
    logic [63:0] tk_val;
    logic [2:0]  tk_code;

    logic        accept;
    logic [7:0]  b;
    logic [2:0]  ty;
    logic [4:0]  ck;

    assign accept    = i_in.valid && i_in.ready;
    assign i_in.ready = !r_out_valid || o_out.ready;
    assign b  = i_in.data_byte;
    assign ty = b[2:0];
    assign ck = b[7:3];

    always_comb begin
        logic        fin;
        t_purpose    fin_p;
        logic [63:0] fin_v;
        logic        bn;
        logic [4:0]  bn_ck;
        t_purpose    bn_p;
        logic        err;
        logic [2:0]  err_c;
        logic [2:0]  idx;
        logic [63:0] acc_new;
        logic [31:0] rem_new;

        n_phase   = r_phase;
        n_purpose = r_purpose;
        n_rem     = r_rem;
        n_acc     = r_acc;
        n_width   = r_width;
        n_err     = r_err;
        tk_have   = 1'b0;
        tk_kind   = K_NIL;
        tk_val    = 64'd0;
        tk_code   = E_NONE;
        fin       = 1'b0;
        fin_p     = P_INT;
        fin_v     = 64'd0;
        bn        = 1'b0;
        bn_ck     = CK_ZERO;
        bn_p      = P_INT;
        err       = 1'b0;
        err_c     = E_NONE;
        idx       = 3'(r_width - r_rem[3:0]);
        acc_new   = 64'd0;
        rem_new   = 32'd0;

        unique case (r_phase)
            PH_NUM: begin
                if (r_purpose == P_REAL) begin
                    acc_new = r_acc | ({56'd0, b} << {idx, 3'b000});
                end else begin
                    acc_new = {r_acc[55:0], b};
                end
                rem_new = (r_rem != 32'd0) ? r_rem - 32'd1 : 32'd0;
                n_acc = acc_new;
                n_rem = rem_new;
                if (rem_new == 32'd0) begin
                    fin   = 1'b1;
                    fin_p = r_purpose;
                    fin_v = acc_new;
                    if (r_width == 4'd4 && acc_new[31]) begin
                        fin_v[63:32] = 32'hFFFF_FFFF;
                    end
                end
            end
            PH_CNTTAG: begin
                if (ty != TY_NUM || ck == CK_REAL) begin
                    err   = 1'b1;
                    err_c = E_BAD_CNTTAG;
                end else begin
                    bn    = 1'b1;
                    bn_ck = ck;
                    bn_p  = r_purpose;
                end
            end
            PH_PAY: begin
                tk_have = 1'b1;
                tk_kind = (r_purpose == P_SBYTES) ? K_STR_BYTE : K_FUNC_BYTE;
                tk_val  = {56'd0, b};
                rem_new = (r_rem != 32'd0) ? r_rem - 32'd1 : 32'd0;
                n_rem   = rem_new;
                if (rem_new == 32'd0) begin
                    n_phase = PH_TAG;
                end
            end
            PH_TAG: begin
                unique case (ty)
                    TY_NIL: begin
                        tk_have = 1'b1;
                        tk_kind = K_NIL;
                    end
                    TY_BOOL: begin
                        tk_have = 1'b1;
                        tk_kind = K_BOOL;
                        tk_val  = {63'd0, ck != CK_ZERO};
                    end
                    TY_NUM: begin
                        if (ck == CK_REAL) begin
                            n_phase   = PH_NUM;
                            n_purpose = P_REAL;
                            n_width   = 4'd8;
                            n_rem     = 32'd8;
                            n_acc     = 64'd0;
                        end else begin
                            bn    = 1'b1;
                            bn_ck = ck;
                            bn_p  = P_INT;
                        end
                    end
                    TY_SSTR: begin
                        fin   = 1'b1;
                        fin_p = P_SLEN;
                        fin_v = {59'd0, ck};
                    end
                    TY_LSTR: begin
                        if (ck == CK_WORD || ck == CK_DWORD) begin
                            bn    = 1'b1;
                            bn_ck = ck;
                            bn_p  = P_SLEN;
                        end else begin
                            err   = 1'b1;
                            err_c = E_BAD_LENCK;
                        end
                    end
                    TY_TABLE: begin
                        if (ck == CK_EXT) begin
                            n_phase   = PH_CNTTAG;
                            n_purpose = P_COUNT;
                        end else begin
                            tk_have = 1'b1;
                            tk_kind = K_TAB_HEAD;
                            tk_val  = {59'd0, ck};
                        end
                    end
                    TY_FUNC: begin
                        if (ck == CK_ZERO) begin
                            n_phase   = PH_CNTTAG;
                            n_purpose = P_FLEN;
                        end else begin
                            fin   = 1'b1;
                            fin_p = P_FLEN;
                            fin_v = {59'd0, ck};
                        end
                    end
                    default: begin
                        err   = 1'b1;
                        err_c = E_BAD_TYPE;
                    end
                endcase
            end
            default: ;
        endcase

        // start of an integer payload
        if (bn) begin
            unique case (bn_ck)
                CK_ZERO: begin
                    fin   = 1'b1;
                    fin_p = bn_p;
                    fin_v = 64'd0;
                end
                CK_BYTE, CK_WORD, CK_DWORD, CK_QWORD: begin
                    n_phase   = PH_NUM;
                    n_purpose = bn_p;
                    n_acc     = 64'd0;
                    unique case (bn_ck)
                        CK_BYTE:  n_width = 4'd1;
                        CK_WORD:  n_width = 4'd2;
                        CK_DWORD: n_width = 4'd4;
                        default:  n_width = 4'd8;
                    endcase
                    n_rem = {28'd0, n_width};
                end
                default: begin
                    err   = 1'b1;
                    err_c = E_BAD_NUMCK;
                end
            endcase
        end

        // a complete value
        if (fin) begin
            n_phase = PH_TAG;
            unique case (fin_p)
                P_INT: begin
                    tk_have = 1'b1;
                    tk_kind = K_INT;
                    tk_val  = fin_v;
                end
                P_REAL: begin
                    tk_have = 1'b1;
                    tk_kind = K_REAL;
                    tk_val  = fin_v;
                end
                P_COUNT: begin
                    if (fin_v[63:31] != 33'd0) begin
                        err   = 1'b1;
                        err_c = E_TRUNC;
                    end else begin
                        tk_have = 1'b1;
                        tk_kind = K_TAB_HEAD;
                        tk_val  = fin_v;
                    end
                end
                default: begin
                    if (fin_v[63:31] != 33'd0) begin
                        err   = 1'b1;
                        err_c = E_TRUNC;
                    end else begin
                        tk_have = 1'b1;
                        tk_kind = (fin_p == P_SLEN) ? K_STR_HEAD : K_FUNC_HEAD;
                        tk_val  = fin_v;
                        if (fin_v != 64'd0) begin
                            n_phase   = PH_PAY;
                            n_purpose = (fin_p == P_SLEN) ? P_SBYTES : P_FBYTES;
                            n_rem     = fin_v[31:0];
                        end
                    end
                end
            endcase
        end

        // element left open at the end of the stream
        if (!err && i_in.stream_end && n_phase != PH_TAG) begin
            err   = 1'b1;
            err_c = E_TRUNC;
        end

        if (err) begin
            n_err   = 1'b1;
            n_phase = PH_TAG;
            tk_have = 1'b1;
            tk_kind = K_ERROR;
            tk_val  = 64'd0;
            tk_code = err_c;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= PH_TAG;
            r_purpose   <= P_INT;
            r_rem       <= 32'd0;
            r_acc       <= 64'd0;
            r_width     <= 4'd0;
            r_err       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept && !r_err) begin
                r_phase   <= n_phase;
                r_purpose <= n_purpose;
                r_rem     <= n_rem;
                r_acc     <= n_acc;
                r_width   <= n_width;
                r_err     <= n_err;
            end
            if (accept) begin
                r_out_valid <= tk_have && !r_err;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_kind  <= tk_kind;
            r_value <= tk_val;
            r_code  <= tk_code;
        end
    end

    assign o_out.valid       = r_out_valid;
    assign o_out.token_kind  = r_kind;
    assign o_out.token_value = r_value;
    assign o_out.error_code  = r_code;

    a_err_sticky : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_err |=> r_err)
        else $error("sticky error cleared without reset");

    a_pay_owed : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_PAY) |-> (r_rem != 32'd0))
        else $error("payload phase with nothing owed");

    a_num_count : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_NUM) |-> (r_rem != 32'd0 && r_rem <= {28'd0, r_width}))
        else $error("number byte count out of range");

    a_err_token : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out.valid && o_out.token_kind == K_ERROR) |-> r_err)
        else $error("error token without latched error");

    a_quiet_after_err : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_err && !r_out_valid) |=> !r_out_valid)
        else $error("token emitted after error latched");

endmodule

// ===== tb/tb_top.sv =====
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import tvst_pkg::*;

    localparam logic [63:0] LEN_MAX     = 64'h7FFF_FFFF;
    localparam int          IDLE_LIMIT  = 1000;
    // tag type with no meaning in the stream format
    localparam logic [2:0]  TY_RESERVED = 3'd3;

    typedef struct packed {
        logic [3:0]  kind;
        logic [63:0] value;
        logic [2:0]  code;
    } t_token;

    logic i_clk;
    logic i_rst_n;

    tvst_in_if  in_if ();
    tvst_out_if out_if ();

    tagged_value_stream_tokenizer dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_if),
        .o_out   (out_if)
    );

    // parser state as the tokenizer should hold it
    t_phase      phase;
    t_purpose    purpose;
    logic [31:0] remaining;
    logic [63:0] accum;
    logic [3:0]  num_width;
    bit          err_latched;
    bit          tok_have;
    t_token      tok;

    t_token      expected_tokens[$];
    logic [7:0]  elem_q[$];

    bit gaps_on;
    int bytes_fed;
    int tokens_checked;
    int mismatches;
    int error_seen;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // ---------------------------------------------------------------- prediction

    function automatic void put_token(input logic [3:0] k, input logic [63:0] v);
        tok_have = 1'b1;
        tok      = '{k, v, E_NONE};
    endfunction

    function automatic void latch_error(input logic [2:0] c);
        err_latched = 1'b1;
        phase       = PH_TAG;
        tok_have    = 1'b1;
        tok         = '{K_ERROR, 64'd0, c};
    endfunction

    function automatic void finish_value(input t_purpose p, input logic [63:0] v);
        phase = PH_TAG;
        case (p)
            P_INT:   put_token(K_INT, v);
            P_REAL:  put_token(K_REAL, v);
            P_COUNT: begin
                if (v > LEN_MAX) latch_error(E_TRUNC);
                else put_token(K_TAB_HEAD, v);
            end
            default: begin
                if (v > LEN_MAX) begin
                    latch_error(E_TRUNC);
                end else begin
                    put_token((p == P_SLEN) ? K_STR_HEAD : K_FUNC_HEAD, v);
                    if (v != 0) begin
                        phase = PH_PAY;
                        if (p == P_SLEN) purpose = P_SBYTES;
                        else purpose = P_FBYTES;
                        remaining = v[31:0];
                    end
                end
            end
        endcase
    endfunction

    function automatic void begin_number(input logic [4:0] ck, input t_purpose p);
        logic [3:0] w;
        case (ck)
            CK_BYTE:  w = 4'd1;
            CK_WORD:  w = 4'd2;
            CK_DWORD: w = 4'd4;
            CK_QWORD: w = 4'd8;
            default:  w = 4'd0;
        endcase
        if (ck == CK_ZERO) begin
            finish_value(p, 64'd0);
        end else if (w == 4'd0) begin
            latch_error(E_BAD_NUMCK);
        end else begin
            phase     = PH_NUM;
            purpose   = p;
            num_width = w;
            remaining = 32'(w);
            accum     = 64'd0;
        end
    endfunction

    function automatic void take_tag(input logic [7:0] b);
        logic [2:0] ty;
        logic [4:0] ck;
        ty = b[2:0];
        ck = b[7:3];
        case (ty)
            TY_NIL:  put_token(K_NIL, 64'd0);
            TY_BOOL: put_token(K_BOOL, 64'(ck != CK_ZERO));
            TY_NUM: begin
                if (ck == CK_REAL) begin
                    phase     = PH_NUM;
                    purpose   = P_REAL;
                    num_width = 4'd8;
                    remaining = 32'd8;
                    accum     = 64'd0;
                end else begin
                    begin_number(ck, P_INT);
                end
            end
            TY_SSTR: finish_value(P_SLEN, 64'(ck));
            TY_LSTR: begin
                if (ck == CK_WORD || ck == CK_DWORD) begin_number(ck, P_SLEN);
                else latch_error(E_BAD_LENCK);
            end
            TY_TABLE: begin
                if (ck == CK_EXT) begin
                    phase   = PH_CNTTAG;
                    purpose = P_COUNT;
                end else begin
                    put_token(K_TAB_HEAD, 64'(ck));
                end
            end
            TY_FUNC: begin
                if (ck == CK_ZERO) begin
                    phase   = PH_CNTTAG;
                    purpose = P_FLEN;
                end else begin
                    finish_value(P_FLEN, 64'(ck));
                end
            end
            default: latch_error(E_BAD_TYPE);
        endcase
    endfunction

    function automatic void take_num(input logic [7:0] b);
        logic [31:0] taken;
        logic [63:0] v;
        // reals arrive little-endian, everything else big-endian
        if (purpose == P_REAL) begin
            taken = 32'(num_width) - remaining;
            accum = accum | (64'(b) << (8 * taken[2:0]));
        end else begin
            accum = {accum[55:0], b};
        end
        if (remaining > 0) remaining = remaining - 1;
        if (remaining == 0) begin
            v = accum;
            if (num_width == 4'd4 && v[31]) v[63:32] = '1;
            finish_value(purpose, v);
        end
    endfunction

    function automatic void clear_parser();
        phase       = PH_TAG;
        purpose     = P_INT;
        remaining   = '0;
        accum       = '0;
        num_width   = '0;
        err_latched = 1'b0;
    endfunction

    function automatic void tokenize_byte(input logic [7:0] b, input bit last);
        if (err_latched) return;
        tok_have = 1'b0;
        case (phase)
            PH_NUM: take_num(b);
            PH_CNTTAG: begin
                if (b[2:0] != TY_NUM || b[7:3] == CK_REAL) latch_error(E_BAD_CNTTAG);
                else begin_number(b[7:3], purpose);
            end
            PH_PAY: begin
                put_token((purpose == P_SBYTES) ? K_STR_BYTE : K_FUNC_BYTE, 64'(b));
                if (remaining > 0) remaining = remaining - 1;
                if (remaining == 0) phase = PH_TAG;
            end
            default: take_tag(b);
        endcase
        // stream ending mid-element replaces whatever this byte produced
        if (last && !err_latched && phase != PH_TAG) latch_error(E_TRUNC);
        if (tok_have) expected_tokens.push_back(tok);
    endfunction

    // ---------------------------------------------------------------- stimulus

    function automatic int ck_bytes(input logic [4:0] ck);
        case (ck)
            CK_BYTE:  return 1;
            CK_WORD:  return 2;
            CK_DWORD: return 4;
            CK_QWORD: return 8;
            default:  return 0;
        endcase
    endfunction

    function automatic logic [4:0] pick_int_ck();
        case ($urandom_range(0, 4))
            0:       return CK_ZERO;
            1:       return CK_BYTE;
            2:       return CK_WORD;
            3:       return CK_DWORD;
            default: return CK_QWORD;
        endcase
    endfunction

    function automatic void push_be(input logic [63:0] v, input int nb);
        for (int i = nb - 1; i >= 0; i--) elem_q.push_back(v[8*i +: 8]);
    endfunction

    function automatic void push_random(input int n);
        for (int i = 0; i < n; i++) elem_q.push_back(8'($urandom));
    endfunction

    // one well-formed element with random content
    function automatic void build_element();
        logic [4:0]  ck;
        logic [63:0] v;
        int          n;
        case ($urandom_range(0, 9))
            0: elem_q.push_back({5'($urandom), TY_NIL});
            1: elem_q.push_back({5'($urandom), TY_BOOL});
            2, 3: begin
                ck = pick_int_ck();
                elem_q.push_back({ck, TY_NUM});
                push_be({$urandom, $urandom}, ck_bytes(ck));
            end
            4: begin
                elem_q.push_back({CK_REAL, TY_NUM});
                push_random(8);
            end
            5: begin
                n = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 31) : $urandom_range(0, 6);
                elem_q.push_back({5'(n), TY_SSTR});
                push_random(n);
            end
            6: begin
                ck = ($urandom_range(0, 1) == 0) ? CK_WORD : CK_DWORD;
                n  = $urandom_range(0, 24);
                elem_q.push_back({ck, TY_LSTR});
                push_be(64'(n), ck_bytes(ck));
                push_random(n);
            end
            7: begin
                if ($urandom_range(0, 1) == 0) begin
                    elem_q.push_back({5'($urandom_range(0, 30)), TY_TABLE});
                end else begin
                    ck = pick_int_ck();
                    v  = ($urandom_range(0, 7) == 0) ? LEN_MAX : {$urandom, $urandom};
                    if (ck == CK_BYTE) v = v & 64'hFF;
                    else if (ck == CK_WORD) v = v & 64'hFFFF;
                    else v = v & LEN_MAX;
                    elem_q.push_back({CK_EXT, TY_TABLE});
                    elem_q.push_back({ck, TY_NUM});
                    push_be(v, ck_bytes(ck));
                end
            end
            default: begin
                if ($urandom_range(0, 1) == 0) begin
                    n = $urandom_range(1, 31);
                    elem_q.push_back({5'(n), TY_FUNC});
                end else begin
                    ck = pick_int_ck();
                    n  = (ck == CK_ZERO) ? 0 : $urandom_range(0, 24);
                    elem_q.push_back({CK_ZERO, TY_FUNC});
                    elem_q.push_back({ck, TY_NUM});
                    push_be(64'(n), ck_bytes(ck));
                end
                push_random(n);
            end
        endcase
    endfunction

    // one request per byte; prediction runs on the edge that takes it
    task automatic send_byte(input logic [7:0] b, input bit last);
        if (gaps_on && $urandom_range(0, 5) == 0) begin
            in_if.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        in_if.valid      <= 1'b1;
        in_if.data_byte  <= b;
        in_if.stream_end <= last;
        do @(posedge i_clk); while (!in_if.ready);
        tokenize_byte(b, last);
        bytes_fed++;
    endtask

    task automatic send_queued(input int end_at);
        foreach (elem_q[i]) send_byte(elem_q[i], i == end_at);
    endtask

    task automatic wait_for_drain();
        in_if.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // ---------------------------------------------------------------- tests

    task automatic test_directed_extremes();
        elem_q = '{{CK_EXT, TY_NIL}};
        send_queued(0);
        elem_q = '{
            {CK_ZERO, TY_BOOL}, {CK_EXT, TY_BOOL}, {CK_ZERO, TY_NUM},
            {CK_BYTE, TY_NUM}, 8'hFF,
            {CK_DWORD, TY_NUM}, 8'h80, 8'h00, 8'h00, 8'h00,
            {CK_ZERO, TY_SSTR}, {5'd30, TY_TABLE},
            {CK_EXT, TY_TABLE}, {CK_BYTE, TY_NUM}, 8'h00,
            {CK_ZERO, TY_FUNC}, {CK_ZERO, TY_NUM},
            {CK_WORD, TY_LSTR}, 8'h00, 8'h00
        };
        send_queued(elem_q.size() - 1);
    endtask

    task automatic test_random_stream(input int fed_target);
        while (bytes_fed < fed_target) begin
            elem_q.delete();
            build_element();
            send_queued(($urandom_range(0, 5) == 0) ? elem_q.size() - 1 : -1);
        end
    endtask

    // the error latches until reset, so only one fault can be shown per run
    task automatic test_sticky_error();
        logic [4:0] ck;
        logic [2:0] ty;
        int         end_at;
        elem_q.delete();
        end_at = -1;
        case ($urandom_range(0, 7))
            0: elem_q.push_back({5'($urandom), TY_RESERVED});
            1: begin
                do ck = 5'($urandom);
                while (ck_bytes(ck) != 0 || ck == CK_ZERO || ck == CK_REAL);
                elem_q.push_back({ck, TY_NUM});
            end
            2: begin
                do ck = 5'($urandom); while (ck == CK_WORD || ck == CK_DWORD);
                elem_q.push_back({ck, TY_LSTR});
            end
            3: begin
                elem_q.push_back({CK_EXT, TY_TABLE});
                if ($urandom_range(0, 1) == 0) begin
                    elem_q.push_back({CK_REAL, TY_NUM});
                end else begin
                    do ty = 3'($urandom); while (ty == TY_NUM);
                    elem_q.push_back({5'($urandom), ty});
                end
            end
            4: begin
                do ck = 5'($urandom);
                while (ck_bytes(ck) != 0 || ck == CK_ZERO || ck == CK_REAL);
                elem_q.push_back({CK_ZERO, TY_FUNC});
                elem_q.push_back({ck, TY_NUM});
            end
            5: begin
                elem_q.push_back({CK_DWORD, TY_LSTR});
                elem_q.push_back({1'b1, 7'($urandom)});
                push_random(3);
            end
            6: begin
                if ($urandom_range(0, 1) == 0) begin
                    elem_q.push_back({CK_EXT, TY_TABLE});
                    elem_q.push_back({CK_QWORD, TY_NUM});
                    push_be({$urandom, 1'b1, 31'($urandom)}, 8);
                end else begin
                    elem_q.push_back({CK_ZERO, TY_FUNC});
                    elem_q.push_back({CK_DWORD, TY_NUM});
                    push_be({32'd0, 1'b1, 31'($urandom)}, 4);
                end
            end
            default: begin
                do begin
                    elem_q.delete();
                    build_element();
                end while (elem_q.size() < 2);
                end_at = $urandom_range(0, elem_q.size() - 2);
            end
        endcase
        send_queued(end_at);
        // everything after the fault must be swallowed
        elem_q.delete();
        for (int i = 0; i < 16; i++) elem_q.push_back(8'($urandom));
        send_queued($urandom_range(0, 15));
    endtask

    // ---------------------------------------------------------------- checking

    function automatic void report(input string what, input t_token want, input t_token got);
        if (mismatches < 10)
            $display("%0t: %s: expected kind %0d value %h code %0d, got kind %0d value %h code %0d",
                     $time, what, want.kind, want.value, want.code,
                     got.kind, got.value, got.code);
        mismatches++;
    endfunction

    function automatic void check_token();
        t_token got;
        t_token want;
        got = '{out_if.token_kind, out_if.token_value, out_if.error_code};
        if (expected_tokens.size() == 0) begin
            report("unexpected token", '0, got);
            return;
        end
        want = expected_tokens.pop_front();
        tokens_checked++;
        if (got.kind == K_ERROR) error_seen = got.code;
        if (got.kind !== want.kind) report("kind mismatch", want, got);
        else if (got.value !== want.value) report("value mismatch", want, got);
        else if (got.code !== want.code) report("code mismatch", want, got);
    endfunction

    initial begin
        int stall_left;
        stall_left = 0;
        out_if.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (out_if.valid && out_if.ready) check_token();
            if (stall_left > 0) begin
                stall_left--;
                out_if.ready <= 1'b0;
            end else if (gaps_on && $urandom_range(0, 7) == 0) begin
                stall_left = $urandom_range(1, 11) - 1;
                out_if.ready <= 1'b0;
            end else begin
                out_if.ready <= 1'b1;
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT) begin
            @(posedge i_clk);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) idle_cycles = 0;
            else idle_cycles++;
        end
        $display("watchdog: no request moved for %0d cycles", IDLE_LIMIT);
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        gaps_on        = 1'b1;
        bytes_fed      = 0;
        tokens_checked = 0;
        mismatches     = 0;
        error_seen     = -1;
        clear_parser();
        i_rst_n          <= 1'b0;
        in_if.valid      <= 1'b0;
        in_if.data_byte  <= '0;
        in_if.stream_end <= 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_directed_extremes();
        test_random_stream(1300);
        wait_for_drain();
        test_random_stream(1600);
        gaps_on = 1'b0;
        test_random_stream(1900);
        test_sticky_error();

        in_if.valid <= 1'b0;
        while (expected_tokens.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Fed %0d stream bytes, %0d tokens compared, %0d mismatching.",
                 bytes_fed, tokens_checked, mismatches);
        $display("Run closed with a latched fault of code %0d and its trailing bytes ignored.",
                 error_seen);
        if (mismatches == 0 && expected_tokens.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
